FILE: rtl/ipclf_pkg.sv
package ipclf_pkg;

    // character codes
    localparam logic [7:0] DOT_CODE    = 8'h2e;
    localparam logic [7:0] COLON_CODE  = 8'h3a;
    localparam logic [7:0] DIGIT_ZERO  = 8'h30;
    localparam logic [7:0] DIGIT_NINE  = 8'h39;
    localparam logic [7:0] UPPER_A     = 8'h41;
    localparam logic [7:0] UPPER_Z     = 8'h5a;
    localparam logic [7:0] LOWER_A     = 8'h61;
    localparam logic [7:0] LOWER_F     = 8'h66;
    localparam logic [7:0] CASE_OFFSET = 8'h20;

    // counter widths and saturation points
    localparam int DOT_W   = 3;
    localparam int COLON_W = 4;
    localparam int LEN_W   = 3;
    localparam int DEC_W   = 10;

    localparam logic [DOT_W-1:0]   DOT_SAT      = 3'd4;
    localparam logic [DOT_W-1:0]   V4_DOTS      = 3'd3;
    localparam logic [COLON_W-1:0] COLON_SAT    = 4'd8;
    localparam logic [COLON_W-1:0] V6_COLONS    = 4'd7;
    localparam logic [LEN_W-1:0]   LEN_SAT      = 3'd5;
    localparam logic [LEN_W-1:0]   DEC_DIGITS   = 3'd3;
    localparam logic [LEN_W-1:0]   V4_LEN_MAX   = 3'd3;
    localparam logic [LEN_W-1:0]   V6_LEN_MAX   = 3'd4;
    localparam logic [DEC_W-1:0]   V4_GROUP_MAX = 10'd255;

    typedef enum logic [1:0] {
        KIND_NEITHER = 2'd0,
        KIND_IPV4    = 2'd1,
        KIND_IPV6    = 2'd2
    } address_kind_t;

    typedef struct packed {
        logic       is_dot;
        logic       is_colon;
        logic       is_digit;
        logic       is_letter;
        logic       is_zero;
        logic [3:0] digit;
    } char_class_t;

endpackage

FILE: rtl/ipclf_char_decode.sv
module ipclf_char_decode (
    input  logic [7:0]             char_code,
    output ipclf_pkg::char_class_t char_class
);
    import ipclf_pkg::*;

    logic [7:0] folded;

    always_comb
    begin
        if (char_code >= UPPER_A && char_code <= UPPER_Z)
        begin
            folded = char_code + CASE_OFFSET;
        end
        else
        begin
            folded = char_code;
        end
        char_class.is_dot    = (folded == DOT_CODE);
        char_class.is_colon  = (folded == COLON_CODE);
        char_class.is_digit  = (folded >= DIGIT_ZERO) && (folded <= DIGIT_NINE);
        char_class.is_letter = (folded >= LOWER_A) && (folded <= LOWER_F);
        char_class.is_zero   = (folded == DIGIT_ZERO);
        char_class.digit     = folded[3:0];
    end

endmodule

FILE: rtl/ipclf_tracker.sv
module ipclf_tracker (
    input  logic                     clk,
    input  logic                     rst_n,
    input  logic                     step,
    input  logic                     last,
    input  ipclf_pkg::char_class_t   char_class,
    output ipclf_pkg::address_kind_t kind
);
    import ipclf_pkg::*;

    logic [DOT_W-1:0]   dot_total_reg,   dot_total_next;
    logic [COLON_W-1:0] colon_total_reg, colon_total_next;
    logic [LEN_W-1:0]   group_len_reg,   group_len_next;
    logic [DEC_W-1:0]   group_dec_reg,   group_dec_next;
    logic               starts_zero_reg, starts_zero_next;
    logic               hex_seen_reg,    hex_seen_next;
    logic               bad_seen_reg,    bad_seen_next;
    logic               v4_failed_reg,   v4_failed_next;
    logic               v6_failed_reg,   v6_failed_next;
    logic               v4_final_fail;
    logic               v6_final_fail;
    logic               is_sep;

    function automatic logic v4_group_bad(
        input logic [LEN_W-1:0] len,
        input logic [DEC_W-1:0] dec,
        input logic             starts_zero
    );
        return (len == '0) || (len > V4_LEN_MAX) || ((len > 3'd1) && starts_zero)
               || (dec > V4_GROUP_MAX);
    endfunction

    function automatic logic v6_group_bad(input logic [LEN_W-1:0] len);
        return (len == '0) || (len > V6_LEN_MAX);
    endfunction

    // state as it stands after the current character
    always_comb
    begin
        is_sep           = char_class.is_dot || char_class.is_colon;
        dot_total_next   = dot_total_reg;
        colon_total_next = colon_total_reg;
        group_len_next   = group_len_reg;
        group_dec_next   = group_dec_reg;
        starts_zero_next = starts_zero_reg;
        hex_seen_next    = hex_seen_reg;
        bad_seen_next    = bad_seen_reg;
        v4_failed_next   = v4_failed_reg;
        v6_failed_next   = v6_failed_reg;

        if (char_class.is_dot)
        begin
            if (dot_total_reg < DOT_SAT)
            begin
                dot_total_next = dot_total_reg + 1'b1;
            end
            v4_failed_next = v4_failed_reg
                             || v4_group_bad(group_len_reg, group_dec_reg, starts_zero_reg);
        end
        if (char_class.is_colon)
        begin
            if (colon_total_reg < COLON_SAT)
            begin
                colon_total_next = colon_total_reg + 1'b1;
            end
            v6_failed_next = v6_failed_reg || v6_group_bad(group_len_reg);
        end

        if (is_sep)
        begin
            group_len_next   = '0;
            group_dec_next   = '0;
            starts_zero_next = 1'b0;
        end
        else
        begin
            bad_seen_next = bad_seen_reg || (!char_class.is_digit && !char_class.is_letter);
            hex_seen_next = hex_seen_reg || char_class.is_letter;
            if (group_len_reg == '0 && char_class.is_zero)
            begin
                starts_zero_next = 1'b1;
            end
            if (group_len_reg < DEC_DIGITS && char_class.is_digit)
            begin
                group_dec_next = group_dec_reg * 10'd10 + {6'd0, char_class.digit};
            end
            if (group_len_reg < LEN_SAT)
            begin
                group_len_next = group_len_reg + 1'b1;
            end
        end

        // the open group at the end of the string is closed too
        v4_final_fail = v4_failed_next || ((dot_total_next != '0)
                        && v4_group_bad(group_len_next, group_dec_next, starts_zero_next));
        v6_final_fail = v6_failed_next
                        || ((colon_total_next != '0) && v6_group_bad(group_len_next));

        kind = KIND_NEITHER;
        if (!bad_seen_next && !((dot_total_next != '0) && (colon_total_next != '0)))
        begin
            if (dot_total_next == V4_DOTS && !hex_seen_next && !v4_final_fail)
            begin
                kind = KIND_IPV4;
            end
            else if (colon_total_next == V6_COLONS && !v6_final_fail)
            begin
                kind = KIND_IPV6;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            dot_total_reg   <= '0;
            colon_total_reg <= '0;
            group_len_reg   <= '0;
            group_dec_reg   <= '0;
            starts_zero_reg <= 1'b0;
            hex_seen_reg    <= 1'b0;
            bad_seen_reg    <= 1'b0;
            v4_failed_reg   <= 1'b0;
            v6_failed_reg   <= 1'b0;
        end
        else if (step)
        begin
            if (last)
            begin
                // next beat opens a new string
                dot_total_reg   <= '0;
                colon_total_reg <= '0;
                group_len_reg   <= '0;
                group_dec_reg   <= '0;
                starts_zero_reg <= 1'b0;
                hex_seen_reg    <= 1'b0;
                bad_seen_reg    <= 1'b0;
                v4_failed_reg   <= 1'b0;
                v6_failed_reg   <= 1'b0;
            end
            else
            begin
                dot_total_reg   <= dot_total_next;
                colon_total_reg <= colon_total_next;
                group_len_reg   <= group_len_next;
                group_dec_reg   <= group_dec_next;
                starts_zero_reg <= starts_zero_next;
                hex_seen_reg    <= hex_seen_next;
                bad_seen_reg    <= bad_seen_next;
                v4_failed_reg   <= v4_failed_next;
                v6_failed_reg   <= v6_failed_next;
            end
        end
    end

endmodule

FILE: rtl/ip_address_text_classifier.sv
// Classifies an address string fed one character per beat (last_char marks the
// end) as IPv4, IPv6 or neither; a single result beat follows each final
// character. One character is taken every clock cycle: each is held in an input
// register and then folded into the running counters and flags, and the final
// character's classification is registered in the output register when that
// input register passes it on. Input ready drops only when a final character
// is waiting and the previous result has not yet been taken.
module ip_address_text_classifier (
    input  logic       clk,
    input  logic       rst_n,
    input  logic       in_valid,
    output logic       in_ready,
    input  logic [7:0] char_code,
    input  logic       last_char,
    output logic       out_valid,
    input  logic       out_ready,
    output logic [1:0] address_kind
);
    import ipclf_pkg::*;

    logic          s1_valid_reg;
    logic [7:0]    s1_char_reg;
    logic          s1_last_reg;
    logic          out_valid_reg;
    address_kind_t kind_reg;
    logic          s1_advance;
    char_class_t   char_class;
    address_kind_t kind;

    // a non-final character never waits on the output side
    assign s1_advance = s1_valid_reg && (!s1_last_reg || !out_valid_reg || out_ready);
    assign in_ready   = !s1_valid_reg || s1_advance;

    ipclf_char_decode u_decode (
        .char_code  (s1_char_reg),
        .char_class (char_class)
    );

    ipclf_tracker u_tracker (
        .clk        (clk),
        .rst_n      (rst_n),
        .step       (s1_advance),
        .last       (s1_last_reg),
        .char_class (char_class),
        .kind       (kind)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (in_ready)
            begin
                s1_valid_reg <= in_valid;
            end
            if (s1_advance && s1_last_reg)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (out_ready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_ready && in_valid)
        begin
            s1_char_reg <= char_code;
            s1_last_reg <= last_char;
        end
        if (s1_advance && s1_last_reg)
        begin
            kind_reg <= kind;
        end
    end

    assign out_valid    = out_valid_reg;
    assign address_kind = kind_reg;

endmodule

FILE: rtl/ipclf_checker.sv
module ipclf_checker (
    input logic       clk,
    input logic       rst_n,
    input logic       in_valid,
    input logic       in_ready,
    input logic [7:0] char_code,
    input logic       last_char,
    input logic       out_valid,
    input logic       out_ready,
    input logic [1:0] address_kind
);
    import ipclf_pkg::*;

    // a stalled result beat holds
    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_ready |=> out_valid && $stable(address_kind))
        else $error("result beat changed while stalled");

    // a stalled input beat holds its payload
    a_in_hold: assert property (@(posedge clk) disable iff (!rst_n)
        in_valid && !in_ready |=> in_valid && $stable(char_code) && $stable(last_char))
        else $error("input beat changed while stalled");

    a_kind_legal: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> (address_kind == KIND_NEITHER || address_kind == KIND_IPV4
                       || address_kind == KIND_IPV6))
        else $error("unused address kind code");

    // input only backs up behind a stalled result
    a_stall_cause: assert property (@(posedge clk) disable iff (!rst_n)
        !in_ready |-> out_valid && !out_ready)
        else $error("input stalled without output back-pressure");

    // a fresh result comes from an accepted final character
    a_result_source: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(out_valid) |-> $past(in_valid && in_ready && last_char, 2))
        else $error("result without a final character");

endmodule

bind ip_address_text_classifier ipclf_checker u_ipclf_checker (
    .clk          (clk),
    .rst_n        (rst_n),
    .in_valid     (in_valid),
    .in_ready     (in_ready),
    .char_code    (char_code),
    .last_char    (last_char),
    .out_valid    (out_valid),
    .out_ready    (out_ready),
    .address_kind (address_kind)
);
